// File: design/rpcsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcsq_pkg
// Shared types, widths and helpers for the range paint / color-set query block.
// ----------------------------------------------------------------------------
package rpcsq_pkg;

	localparam int POS_W             = 11;
	localparam int OP_W              = 2;
	localparam int COLOR_W           = 5;
	localparam int MASK_W            = 30;
	localparam int NUM_COLORS        = 30;
	localparam int MAX_POSITIONS_DEF = 1024;

	localparam logic [COLOR_W-1:0] INIT_COLOR = COLOR_W'(2);

	localparam logic [OP_W-1:0] OP_QUERY  = OP_W'(0);
	localparam logic [OP_W-1:0] OP_PAINT  = OP_W'(1);
	localparam logic [OP_W-1:0] OP_REINIT = OP_W'(2);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// one-hot mask of a color number, zero for color 0 or out of range
	function automatic logic [MASK_W-1:0] color_to_mask(input logic [COLOR_W-1:0] c);
		logic [63:0] m;
		m = 64'd0;
		if (c != '0 && 32'(c) <= NUM_COLORS) begin
			m = 64'd1 << (c - COLOR_W'(1));
		end
		return m[MASK_W-1:0];
	endfunction

endpackage : rpcsq_pkg
`default_nettype wire

// File: design/rpcsq_color_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpcsq_color_ram
// One color code per position, single port, registered read data.
// ----------------------------------------------------------------------------
module rpcsq_color_ram
	import rpcsq_pkg::*;
#(
	parameter int DEPTH = MAX_POSITIONS_DEF,
	parameter int AW    = $clog2(MAX_POSITIONS_DEF)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      addr,
	input  wire logic [COLOR_W-1:0] wdata,
	output logic      [COLOR_W-1:0] rdata_q
);

	logic [COLOR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

endmodule : rpcsq_color_ram
`default_nettype wire

// File: design/range_paint_color_set_query.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_paint_color_set_query
// Range paint and color-set query over positions 1..num_positions.
// ----------------------------------------------------------------------------
//  channel   signals                                            dir
//  input     in_valid, in_ready, operation, range_left,
//            range_right, paint_color                           in
//  result    out_valid, out_ready, color_mask                   out
//  config    cfg_valid, cfg_ready, cfg_data (num_positions)     in
//
//  one sequencer walks the clipped range through a single-port color ram,
//  one position per cycle: a paint writes each position, a query reads each
//  one into the mask; an empty range or unused operation skips the walk.
//  reinit, a config write and reset each run a clearing pass over all
//  MAX_POSITIONS positions, with in_ready low throughout.
//  a finished query result waits in the output register; a new word is taken
//  meanwhile, and the next query holds in its last state until the result leaves.
//  MAX_POSITIONS range 2..1024.
// ----------------------------------------------------------------------------
module range_paint_color_set_query
	import rpcsq_pkg::*;
#(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OP_W-1:0]    operation,
	input  wire logic [POS_W-1:0]   range_left,
	input  wire logic [POS_W-1:0]   range_right,
	input  wire logic [COLOR_W-1:0] paint_color,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic      [MASK_W-1:0]  color_mask,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [POS_W-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_POSITIONS);
	localparam logic [POS_W-1:0] MAX_P = POS_W'(MAX_POSITIONS);
	localparam logic [AW-1:0]    LAST_A = AW'(MAX_POSITIONS - 1);

	state_t state_q, state_d;

	logic [POS_W-1:0]   npos_q;
	logic [AW-1:0]      addr_q, last_q;
	logic               wr_q;
	logic [COLOR_W-1:0] color_q;
	logic               rv_q;
	logic [MASK_W-1:0]  acc_q;
	logic               out_valid_q;
	logic [MASK_W-1:0]  color_mask_q;

	logic [POS_W-1:0]   lo_c, hi_c;
	logic               empty;
	logic               in_acc, cfg_acc, at_last, out_free;
	logic               ram_we;
	logic [COLOR_W-1:0] ram_wdata, ram_rdata_q;
	logic [POS_W-1:0]   cfg_clip;

	assign in_acc   = in_valid && in_ready;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign at_last  = addr_q == last_q;
	assign out_free = !out_valid_q || out_ready;

	// clip the range to 1..num_positions and the config value to 1..MAX_POSITIONS
	always_comb begin
		lo_c  = (range_left == '0) ? POS_W'(1) : range_left;
		hi_c  = (range_right > npos_q) ? npos_q : range_right;
		empty = lo_c > hi_c;
		if (cfg_data == '0) begin
			cfg_clip = POS_W'(1);
		end else if (cfg_data > MAX_P) begin
			cfg_clip = MAX_P;
		end else begin
			cfg_clip = cfg_data;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (at_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (cfg_acc) begin
					state_d = ST_CLEAR;
				end else if (in_acc) begin
					unique case (operation)
						OP_QUERY:  state_d = empty ? ST_DONE : ST_RUN;
						OP_PAINT:  state_d = (empty || color_to_mask(paint_color) == '0)
							? ST_IDLE : ST_RUN;
						OP_REINIT: state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RUN:   if (at_last) state_d = wr_q ? ST_IDLE : ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		// a pending config write goes first
		in_ready  = state_q == ST_IDLE && !cfg_valid;
		cfg_ready = state_q == ST_IDLE;
		ram_we    = (state_q == ST_CLEAR) || (state_q == ST_RUN && wr_q);
		ram_wdata = (state_q == ST_CLEAR) ? INIT_COLOR : color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			npos_q      <= MAX_P;
			addr_q      <= '0;
			last_q      <= LAST_A;
			wr_q        <= 1'b0;
			rv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= state_q == ST_RUN && !wr_q;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == ST_CLEAR || state_q == ST_RUN) begin
				addr_q <= addr_q + AW'(1);
			end
			if (state_q == ST_IDLE) begin
				if (cfg_acc) begin
					npos_q <= cfg_clip;
					addr_q <= '0;
					last_q <= LAST_A;
				end else if (in_acc) begin
					wr_q <= operation == OP_PAINT;
					if (operation == OP_REINIT) begin
						addr_q <= '0;
						last_q <= LAST_A;
					end else begin
						addr_q <= AW'(lo_c - POS_W'(1));
						last_q <= AW'(hi_c - POS_W'(1));
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			color_q <= paint_color;
			acc_q   <= '0;
		end else if (rv_q) begin
			acc_q <= acc_q | color_to_mask(ram_rdata_q);
		end
		if (state_q == ST_DONE && out_free) begin
			color_mask_q <= acc_q;
		end
	end

	rpcsq_color_ram #(
		.DEPTH (MAX_POSITIONS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.addr    (addr_q),
		.wdata   (ram_wdata),
		.rdata_q (ram_rdata_q)
	);

	assign out_valid  = out_valid_q;
	assign color_mask = color_mask_q;

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rv_q)
		else $error("read in flight while idle");

	a_drain_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> rv_q)
		else $error("drain without last read");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");

endmodule : range_paint_color_set_query
`default_nettype wire

// File: sim/range_paint_color_set_query_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_paint_color_set_query_tb
// Drives paints, queries and reinits over several row sizes, keeps a plain
// per-position color array as the expected state and compares each returned
// color mask against it in order.
// ----------------------------------------------------------------------------
module range_paint_color_set_query_tb;
	import rpcsq_pkg::*;

	localparam int MAXP = MAX_POSITIONS_DEF;
	localparam logic [OP_W-1:0] OP_SPARE = OP_W'(3);

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [OP_W-1:0]    operation;
	logic [POS_W-1:0]   range_left;
	logic [POS_W-1:0]   range_right;
	logic [COLOR_W-1:0] paint_color;
	logic               out_valid;
	logic               out_ready;
	logic [MASK_W-1:0]  color_mask;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [POS_W-1:0]   cfg_data;

	// expected row contents and size
	logic [MASK_W-1:0] row_colors [1:MAXP];
	int                row_size;
	logic [MASK_W-1:0] mask_queue [$];
	int                errors;
	bit                long_hold;
	int                hold_cycles;

	range_paint_color_set_query u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.range_left (range_left),
		.range_right(range_right),
		.paint_color(paint_color),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.color_mask (color_mask),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void repaint_all();
		for (int i = 1; i <= MAXP; i++) row_colors[i] = MASK_W'(2);
	endfunction

	// expected effect of one word; queues a mask for a query
	function automatic void predict_word(logic [OP_W-1:0] op, logic [POS_W-1:0] l,
			logic [POS_W-1:0] r, logic [COLOR_W-1:0] c);
		int lo;
		int hi;
		logic [MASK_W-1:0] acc;
		lo = (l < 1) ? 1 : int'(l);
		hi = (int'(r) > row_size) ? row_size : int'(r);
		acc = '0;
		if (op == OP_QUERY) begin
			for (int i = lo; i <= hi; i++) acc |= row_colors[i];
			mask_queue = {mask_queue, acc};
		end else if (op == OP_PAINT) begin
			if (c >= 1 && c <= NUM_COLORS)
				for (int i = lo; i <= hi; i++) row_colors[i] = MASK_W'(1) << (c - 1);
		end else if (op == OP_REINIT) begin
			repaint_all();
		end
	endfunction

	task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] l,
			logic [POS_W-1:0] r, logic [COLOR_W-1:0] c);
		in_valid    <= 1'b1;
		operation   <= op;
		range_left  <= l;
		range_right <= r;
		paint_color <= c;
		predict_word(op, l, r, c);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic idle_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		idle_input(1);
		while (mask_queue.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		// a trailing paint or reinit may still be running
		repeat (MAXP + 50) @(posedge clk);
	endtask

	task automatic write_size(logic [POS_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		row_size = (v < 1) ? 1 : ((int'(v) > MAXP) ? MAXP : int'(v));
		repaint_all();
	endtask

	task automatic send_random(int n, int size_hint);
		int burst;
		int lo;
		int hi;
		logic [OP_W-1:0] op;
		logic [COLOR_W-1:0] c;
		burst = 0;
		for (int k = 0; k < n; k++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 12);
				if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 15));
			end
			burst--;
			case ($urandom_range(0, 19))
				0:       op = OP_REINIT;
				1:       op = OP_SPARE;
				2, 3, 4, 5, 6, 7, 8: op = OP_PAINT;
				default: op = OP_QUERY;
			endcase
			lo = $urandom_range(1, size_hint);
			hi = lo + $urandom_range(0, 40);
			if ($urandom_range(0, 9) == 0) begin
				lo = $urandom_range(0, 2047);
				hi = $urandom_range(0, 2047);
			end
			c = ($urandom_range(0, 15) == 0) ? COLOR_W'($urandom_range(0, 31))
				: COLOR_W'($urandom_range(1, NUM_COLORS));
			send_word(op, POS_W'(lo), POS_W'(hi), c);
		end
	endtask

	task automatic test_directed();
		send_word(OP_QUERY, 11'd1, 11'd1024, 5'd0);
		send_word(OP_PAINT, 11'd1, 11'd1, 5'd1);
		send_word(OP_PAINT, 11'd1024, 11'd1024, 5'd30);
		send_word(OP_PAINT, 11'd500, 11'd520, 5'd17);
		send_word(OP_QUERY, 11'd1, 11'd1024, 5'd31);
		send_word(OP_QUERY, 11'd510, 11'd2047, 5'd0);
		send_word(OP_QUERY, 11'd0, 11'd0, 5'd0);
		send_word(OP_QUERY, 11'd600, 11'd400, 5'd0);
		send_word(OP_PAINT, 11'd900, 11'd100, 5'd5);
		send_word(OP_PAINT, 11'd10, 11'd20, 5'd0);
		send_word(OP_PAINT, 11'd10, 11'd20, 5'd31);
		send_word(OP_SPARE, 11'd2047, 11'd2047, 5'd31);
		send_word(OP_QUERY, 11'd1, 11'd30, 5'd0);
		send_word(OP_REINIT, 11'd0, 11'd0, 5'd0);
		send_word(OP_QUERY, 11'd1, 11'd1024, 5'd0);
		send_word(OP_PAINT, 11'h555, 11'h2aa, 5'h15);
		send_word(OP_PAINT, 11'h2aa, 11'h3ff, 5'h0a);
		send_word(OP_QUERY, 11'd680, 11'd700, 5'd0);
	endtask

	task automatic test_sizes();
		write_size(11'd1);
		send_word(OP_PAINT, 11'd1, 11'd5, 5'd9);
		send_word(OP_QUERY, 11'd1, 11'd1, 5'd0);
		send_word(OP_QUERY, 11'd2, 11'd9, 5'd0);
		send_random(40, 2);
		write_size(11'd0);
		send_random(20, 2);
		write_size(11'd2047);
		send_random(20, 1024);
		write_size(11'd37);
		send_random(200, 37);
	endtask

	task automatic test_backpressure();
		write_size(11'd64);
		long_hold = 1'b1;
		send_random(60, 64);
		long_hold = 1'b0;
	endtask

	task automatic test_random_full();
		write_size(11'd1024);
		send_random(350, 1000);
	endtask

	// receiver: stall pattern, long hold on request
	initial begin
		out_ready   = 1'b0;
		hold_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold && hold_cycles < 400) begin
				hold_cycles++;
				out_ready <= 1'b0;
			end else begin
				case ($urandom_range(0, 7))
					0, 1:    out_ready <= 1'b0;
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (mask_queue.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, color_mask);
				errors++;
			end else begin
				if (color_mask !== mask_queue[0]) begin
					$display("%0t: color_mask expected %h actual %h", $time,
						mask_queue[0], color_mask);
					errors++;
				end
				void'(mask_queue.pop_front());
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = '0;
		range_left  = '0;
		range_right = '0;
		paint_color = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		errors      = 0;
		long_hold   = 1'b0;
		row_size    = MAXP;
		repaint_all();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_sizes();
		test_backpressure();
		test_random_full();
		drain();
		if (errors == 0 && mask_queue.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#60ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
